>>> src/csvtok_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the CSV field tokenizer modules.
// No dependencies.
package csvtok_pkg;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Saturation point of the column counter
    localparam logic [3:0] COL_SAT = 4'd15;

    // Configuration register indexes and reset values
    localparam logic REG_COLUMN_COUNT = 1'b0;
    localparam logic REG_SKIP_HEADER  = 1'b1;
    localparam logic [3:0] COLUMN_COUNT_RESET = 4'd9;
    localparam logic SKIP_HEADER_RESET = 1'b1;

    // Result kinds
    localparam logic KIND_CONTENT   = 1'b0;
    localparam logic KIND_FIELD_END = 1'b1;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CONTENT,
        OP_FIELD,
        OP_ROW
    } cmd_op_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic       item_kind;
        logic [3:0] column;
        logic [7:0] data_byte;
        logic       row_end;
        logic       last;
    } out_word_t;

    // One classified byte: an optional first action and an optional
    // end-of-text row close.
    typedef struct packed {
        cmd_op_t    a_op;
        logic [3:0] a_col;
        logic [7:0] a_data;
        logic       b_row;
        logic [3:0] b_col;
    } cmd_t;

endpackage

>>> src/csvtok_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the tokenizer front and back.
// Depends on csvtok_pkg.
module csvtok_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csvtok_pkg::cmd_t    wdata,
    output logic                full,
    input  logic                pop,
    output csvtok_pkg::cmd_t    rdata,
    output logic                nonempty
);

    localparam int PtrW  = csvtok_pkg::QUEUE_PTR_W;
    localparam int Depth = csvtok_pkg::QUEUE_DEPTH;

    csvtok_pkg::cmd_t entries [Depth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW:0]    count_reg;
    logic [PtrW:0]    count_next;

    assign full     = (count_reg == (PtrW+1)'(Depth));
    assign nonempty = (count_reg != '0);
    assign rdata    = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("command pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("command popped from empty queue");
`endif

endmodule

>>> src/csvtok_front.sv
`timescale 1ns / 1ps
// Tokenizer front: parse state and byte classification into commands.
// Depends on csvtok_pkg.
module csvtok_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  csvtok_pkg::in_word_t  word,
    input  logic                  skip_header,
    input  logic [3:0]            eff_count,
    output logic                  cmd_valid,
    output csvtok_pkg::cmd_t      cmd
);

    logic       header_passed_reg, header_passed_next;
    logic       quoted_mode_reg, quoted_mode_next;
    logic       quote_pending_reg, quote_pending_next;
    logic       has_content_reg, has_content_next;
    logic [3:0] column_index_reg, column_index_next;

    logic       in_header;
    logic       do_outside;
    logic [7:0] b;
    csvtok_pkg::cmd_op_t op;
    logic       op_live;

    assign b = word.text_byte;

    always_comb
    begin
        header_passed_next = header_passed_reg;
        quoted_mode_next   = quoted_mode_reg;
        quote_pending_next = quote_pending_reg;
        has_content_next   = has_content_reg;
        column_index_next  = column_index_reg;
        in_header  = skip_header && !header_passed_reg;
        do_outside = 1'b0;
        op         = csvtok_pkg::OP_NONE;

        if (in_header)
        begin
            if (b == csvtok_pkg::CH_LF)
            begin
                header_passed_next = 1'b1;
            end
        end
        else if (quoted_mode_reg)
        begin
            if (quote_pending_reg)
            begin
                quote_pending_next = 1'b0;
                if (b == csvtok_pkg::CH_QUOTE)
                begin
                    op = csvtok_pkg::OP_CONTENT;
                    has_content_next = 1'b1;
                end
                else
                begin
                    quoted_mode_next = 1'b0;
                    do_outside = 1'b1;
                end
            end
            else if (b == csvtok_pkg::CH_QUOTE)
            begin
                quote_pending_next = 1'b1;
            end
            else
            begin
                op = csvtok_pkg::OP_CONTENT;
                has_content_next = 1'b1;
            end
        end
        else
        begin
            do_outside = 1'b1;
        end

        if (do_outside)
        begin
            priority if (b == csvtok_pkg::CH_QUOTE && !has_content_reg)
            begin
                quoted_mode_next = 1'b1;
            end
            else if (b == csvtok_pkg::CH_COMMA)
            begin
                op = csvtok_pkg::OP_FIELD;
                has_content_next = 1'b0;
                if (column_index_reg < csvtok_pkg::COL_SAT)
                begin
                    column_index_next = column_index_reg + 1'b1;
                end
            end
            else if (b == csvtok_pkg::CH_LF)
            begin
                op = csvtok_pkg::OP_ROW;
                has_content_next  = 1'b0;
                column_index_next = '0;
            end
            else if (b == csvtok_pkg::CH_CR)
            begin
                op = csvtok_pkg::OP_NONE;
            end
            else
            begin
                op = csvtok_pkg::OP_CONTENT;
                has_content_next = 1'b1;
            end
        end

        // Drop content and comma field ends of suppressed columns
        op_live = (op == csvtok_pkg::OP_ROW) ||
                  ((op != csvtok_pkg::OP_NONE) && (column_index_reg < eff_count));

        cmd.a_op   = op_live ? op : csvtok_pkg::OP_NONE;
        cmd.a_col  = column_index_reg;
        cmd.a_data = b;
        cmd.b_row  = 1'b0;
        cmd.b_col  = column_index_next;

        if (word.end_of_text)
        begin
            if (!in_header)
            begin
                if (quote_pending_next)
                begin
                    quoted_mode_next = 1'b0;
                end
                cmd.b_row = has_content_next || (column_index_next != '0) ||
                            quoted_mode_next;
            end
            // Start the next text fresh
            header_passed_next = 1'b0;
            quoted_mode_next   = 1'b0;
            quote_pending_next = 1'b0;
            has_content_next   = 1'b0;
            column_index_next  = '0;
        end

        cmd_valid = accept && (op_live || cmd.b_row);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_passed_reg <= 1'b0;
            quoted_mode_reg   <= 1'b0;
            quote_pending_reg <= 1'b0;
            has_content_reg   <= 1'b0;
            column_index_reg  <= '0;
        end
        else if (accept)
        begin
            header_passed_reg <= header_passed_next;
            quoted_mode_reg   <= quoted_mode_next;
            quote_pending_reg <= quote_pending_next;
            has_content_reg   <= has_content_next;
            column_index_reg  <= column_index_next;
        end
    end

endmodule

>>> src/csvtok_back.sv
`timescale 1ns / 1ps
// Tokenizer back: expands queued commands into result words, one per cycle
// while the output is not stalled, through an output register. Depends on csvtok_pkg.
module csvtok_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [3:0]             eff_count,
    input  logic                   head_valid,
    input  csvtok_pkg::cmd_t       head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output csvtok_pkg::out_word_t  out_item
);

    logic       phase_b_reg;
    logic       mid_reg;
    logic [3:0] pos_reg;
    logic       out_valid_reg;
    csvtok_pkg::out_word_t out_item_reg;

    logic       load;
    logic       use_a;
    logic       more_b;
    logic       seg_done;
    logic [3:0] start_col;
    logic [3:0] cur;
    csvtok_pkg::out_word_t item;

    always_comb
    begin
        load      = head_valid && (!out_valid_reg || !out_stall);
        use_a     = !phase_b_reg && (head.a_op != csvtok_pkg::OP_NONE);
        more_b    = use_a && head.b_row;
        start_col = use_a ? head.a_col : head.b_col;
        cur       = mid_reg ? pos_reg : start_col;

        item.item_kind = csvtok_pkg::KIND_FIELD_END;
        item.column    = cur;
        item.data_byte = '0;
        item.row_end   = 1'b0;
        item.last      = 1'b0;
        seg_done       = 1'b1;

        if (use_a && head.a_op == csvtok_pkg::OP_CONTENT)
        begin
            item.item_kind = csvtok_pkg::KIND_CONTENT;
            item.column    = head.a_col;
            item.data_byte = head.a_data;
        end
        else if (use_a && head.a_op == csvtok_pkg::OP_FIELD)
        begin
            item.column = head.a_col;
        end
        else if (cur < eff_count)
        begin
            // Pad empty fields up to the column count
            item.row_end = ({1'b0, cur} + 5'd1 == {1'b0, eff_count});
            seg_done     = item.row_end;
        end
        else
        begin
            item.row_end = 1'b1;
        end

        item.last = seg_done && !more_b;
        pop       = load && item.last;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_b_reg   <= 1'b0;
            mid_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (seg_done)
                begin
                    mid_reg     <= 1'b0;
                    phase_b_reg <= more_b;
                end
                else
                begin
                    mid_reg <= 1'b1;
                    pos_reg <= cur + 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_row_end_is_field_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.row_end
        |-> out_item_reg.item_kind == csvtok_pkg::KIND_FIELD_END)
        else $error("row end flagged on a content word");

    a_content_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.item_kind == csvtok_pkg::KIND_CONTENT
        |-> out_item_reg.column < eff_count)
        else $error("content word from a suppressed column");

    a_expansion_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_reg || phase_b_reg) |-> head_valid)
        else $error("expansion in progress without a queued command");
`endif

endmodule

>>> src/csv_field_tokenizer.sv
`timescale 1ns / 1ps
// Streaming CSV field tokenizer, top level.
// Depends on csvtok_pkg, csvtok_front, csvtok_fifo, csvtok_back.
//
// Accepts one text byte per cycle while in_stall is low and emits content
// words tagged with their column, field-end words, and padding field ends up
// to the column count at each row end; with skip_header set, everything
// through the first newline is discarded, and end_of_text closes any open row
// and resets the parse state. The front classifies a byte in the cycle it is
// taken and writes at most one command into a four-entry queue; in_stall
// rises only when that queue is full. The back drains the queue at one result
// word per cycle, while out_stall is low, into an output register; a byte
// with no result costs nothing at the back, and a row end expands into
// field-end words that pad up to the column count, at most 15. Write
// column_count and skip_header only while the block is idle.
module csv_field_tokenizer
#(
    parameter int MAX_COLUMNS = 15
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  csvtok_pkg::in_word_t   in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output csvtok_pkg::out_word_t  out_item,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [3:0]             cfg_data
);

    logic [3:0] column_count_reg;
    logic       skip_header_reg;
    logic [3:0] eff_count;

    logic             accept;
    logic             cmd_valid;
    csvtok_pkg::cmd_t cmd;
    logic             q_full;
    logic             q_nonempty;
    logic             q_pop;
    csvtok_pkg::cmd_t q_head;

    always_comb
    begin
        if (int'(column_count_reg) > MAX_COLUMNS)
        begin
            eff_count = 4'(MAX_COLUMNS);
        end
        else
        begin
            eff_count = column_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= csvtok_pkg::COLUMN_COUNT_RESET;
            skip_header_reg  <= csvtok_pkg::SKIP_HEADER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csvtok_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                csvtok_pkg::REG_SKIP_HEADER:  skip_header_reg  <= cfg_data[0];
                default:                      skip_header_reg  <= skip_header_reg;
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    csvtok_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .word        (in_item),
        .skip_header (skip_header_reg),
        .eff_count   (eff_count),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    csvtok_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_valid),
        .wdata    (cmd),
        .full     (q_full),
        .pop      (q_pop),
        .rdata    (q_head),
        .nonempty (q_nonempty)
    );

    csvtok_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_count  (eff_count),
        .head_valid (q_nonempty),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule
